/* src/bsp_pkg.sv */
`default_nettype none

package bsp_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 4096;
    localparam int unsigned QUEUE_DEPTH     = 4;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [31:0] INFO_BYTES    = 32'd40;
    localparam logic [15:0] PLANES_ONE    = 16'd1;
    localparam logic [15:0] DEPTH_24      = 16'd24;
    localparam logic [31:0] HEADER_BYTES  = 32'd54;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXELS = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    localparam logic [2:0] ST_PIXEL     = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_BAD_FMT   = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
    localparam logic [2:0] ST_BAD_OFS   = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    typedef struct packed {
        logic        run_end;
        logic [2:0]  status;
        logic        last_pixel;
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } bsp_result_t;

endpackage

`default_nettype wire

/* src/bsp_parser.sv */
`default_nettype none

module bsp_parser import bsp_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_accept,
    input  wire logic [7:0]  data_byte,
    input  wire logic        file_end,
    output bsp_result_t      res0,
    output bsp_result_t      res1,
    output logic [1:0]       res_count
);

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

    logic [2:0]       phase_reg,  phase_next;
    logic [31:0]      count_reg,  count_next;
    logic [15:0]      sig_reg,    sig_next;
    logic [31:0]      offset_reg, offset_next;
    logic [31:0]      info_reg,   info_next;
    logic [31:0]      width_reg,  width_next;
    logic [31:0]      height_reg, height_next;
    logic [15:0]      planes_reg, planes_next;
    logic [15:0]      depth_reg,  depth_next;
    logic [31:0]      comp_reg,   comp_next;
    logic [DIM_W-1:0] col_reg,    col_next;
    logic [DIM_W-1:0] frow_reg,   frow_next;
    logic [1:0]       tri_reg,    tri_next;
    logic [15:0]      part_reg,   part_next;
    logic [1:0]       pad_reg,    pad_next;

    logic [2:0]  err_code;
    logic        pixel_out;
    logic        err_out;
    logic        trunc_out;
    bsp_result_t pix_res;
    bsp_result_t err_res;
    bsp_result_t trunc_res;

    always_comb begin
        if (sig_reg != BMP_SIGNATURE) begin
            err_code = ST_BAD_SIG;
        end else if (info_reg != INFO_BYTES || planes_reg != PLANES_ONE ||
                     depth_reg != DEPTH_24 || comp_reg != 32'd0) begin
            err_code = ST_BAD_FMT;
        end else if (width_reg == 32'd0 || width_reg > 32'(MAX_DIM) ||
                     height_reg == 32'd0 || height_reg > 32'(MAX_DIM)) begin
            err_code = ST_BAD_SIZE;
        end else if (offset_reg < HEADER_BYTES) begin
            err_code = ST_BAD_OFS;
        end else begin
            err_code = ST_PIXEL;
        end
    end

    always_comb begin
        logic [5:0]       pos;
        logic [1:0]       lane;
        logic [31:0]      count_inc;
        logic [DIM_W-1:0] col_inc;
        logic [DIM_W-1:0] frow_inc;

        pos       = count_reg[5:0];
        lane      = '0;
        count_inc = count_reg + 32'd1;
        col_inc   = col_reg + DIM_W'(1);
        frow_inc  = frow_reg + DIM_W'(1);

        phase_next  = phase_reg;
        count_next  = count_reg;
        sig_next    = sig_reg;
        offset_next = offset_reg;
        info_next   = info_reg;
        width_next  = width_reg;
        height_next = height_reg;
        planes_next = planes_reg;
        depth_next  = depth_reg;
        comp_next   = comp_reg;
        col_next    = col_reg;
        frow_next   = frow_reg;
        tri_next    = tri_reg;
        part_next   = part_reg;
        pad_next    = pad_reg;
        pixel_out   = 1'b0;
        err_out     = 1'b0;

        pix_res            = '0;
        pix_res.blue       = part_reg[7:0];
        pix_res.green      = part_reg[15:8];
        pix_res.red        = data_byte;
        pix_res.column     = 12'(col_reg);
        pix_res.row        = height_reg[11:0] - 12'd1 - 12'(frow_reg);
        pix_res.last_pixel = (32'(frow_reg) == height_reg - 32'd1) &&
                             (32'(col_reg) == width_reg - 32'd1);
        pix_res.status     = ST_PIXEL;

        err_res        = '0;
        err_res.status = err_code;

        unique case (phase_reg)
            PH_HEADER: begin
                case (pos) inside
                    [6'd0:6'd1]: begin
                        sig_next[{pos[0], 3'b000} +: 8] = sig_reg[{pos[0], 3'b000} +: 8] | data_byte;
                    end
                    [6'd10:6'd13]: begin
                        lane = 2'(pos - 6'd10);
                        offset_next[{lane, 3'b000} +: 8] = offset_reg[{lane, 3'b000} +: 8] | data_byte;
                    end
                    [6'd14:6'd17]: begin
                        lane = 2'(pos - 6'd14);
                        info_next[{lane, 3'b000} +: 8] = info_reg[{lane, 3'b000} +: 8] | data_byte;
                    end
                    [6'd18:6'd21]: begin
                        lane = 2'(pos - 6'd18);
                        width_next[{lane, 3'b000} +: 8] = width_reg[{lane, 3'b000} +: 8] | data_byte;
                    end
                    [6'd22:6'd25]: begin
                        lane = 2'(pos - 6'd22);
                        height_next[{lane, 3'b000} +: 8] = height_reg[{lane, 3'b000} +: 8] | data_byte;
                    end
                    [6'd26:6'd27]: begin
                        planes_next[{pos[0], 3'b000} +: 8] = planes_reg[{pos[0], 3'b000} +: 8] | data_byte;
                    end
                    [6'd28:6'd29]: begin
                        depth_next[{pos[0], 3'b000} +: 8] = depth_reg[{pos[0], 3'b000} +: 8] | data_byte;
                    end
                    [6'd30:6'd33]: begin
                        lane = 2'(pos - 6'd30);
                        comp_next[{lane, 3'b000} +: 8] = comp_reg[{lane, 3'b000} +: 8] | data_byte;
                    end
                    default: ;
                endcase
                count_next = count_inc;
                if (count_inc == HEADER_BYTES) begin
                    if (err_code != ST_PIXEL) begin
                        err_out    = 1'b1;
                        phase_next = PH_ERROR;
                    end else if (offset_reg == HEADER_BYTES) begin
                        phase_next = PH_PIXELS;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                count_next = count_inc;
                if (count_inc == offset_reg) begin
                    phase_next = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                if (pad_reg != 2'd0) begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_next == 2'd0 && 32'(frow_reg) >= height_reg) begin
                        phase_next = PH_DONE;
                    end
                end else if (tri_reg != 2'd2) begin
                    part_next[{tri_reg[0], 3'b000} +: 8] = data_byte;
                    tri_next = tri_reg + 2'd1;
                end else begin
                    pixel_out = 1'b1;
                    tri_next  = 2'd0;
                    part_next = '0;
                    if (32'(col_inc) >= width_reg) begin
                        col_next  = '0;
                        frow_next = frow_inc;
                        pad_next  = width_reg[1:0];
                        if (width_reg[1:0] == 2'd0 && 32'(frow_inc) >= height_reg) begin
                            phase_next = PH_DONE;
                        end
                    end else begin
                        col_next = col_inc;
                    end
                end
            end
            default: ;
        endcase

        trunc_out = file_end && (phase_next == PH_HEADER || phase_next == PH_SKIP ||
                                 phase_next == PH_PIXELS);

        if (file_end) begin
            phase_next  = PH_HEADER;
            count_next  = '0;
            sig_next    = '0;
            offset_next = '0;
            info_next   = '0;
            width_next  = '0;
            height_next = '0;
            planes_next = '0;
            depth_next  = '0;
            comp_next   = '0;
            col_next    = '0;
            frow_next   = '0;
            tri_next    = '0;
            part_next   = '0;
            pad_next    = '0;
        end
    end

    always_comb begin
        trunc_res         = '0;
        trunc_res.status  = ST_TRUNCATED;
        trunc_res.run_end = 1'b1;
        res1              = trunc_res;
        if (pixel_out) begin
            res0 = pix_res;
        end else if (err_out) begin
            res0 = err_res;
        end else begin
            res0 = trunc_res;
        end
        res0.run_end = !((pixel_out || err_out) && trunc_out);
        res_count    = 2'(pixel_out || err_out) + 2'(trunc_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            count_reg  <= '0;
            sig_reg    <= '0;
            offset_reg <= '0;
            info_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            planes_reg <= '0;
            depth_reg  <= '0;
            comp_reg   <= '0;
            col_reg    <= '0;
            frow_reg   <= '0;
            tri_reg    <= '0;
            part_reg   <= '0;
            pad_reg    <= '0;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            sig_reg    <= sig_next;
            offset_reg <= offset_next;
            info_reg   <= info_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            planes_reg <= planes_next;
            depth_reg  <= depth_next;
            comp_reg   <= comp_next;
            col_reg    <= col_next;
            frow_reg   <= frow_next;
            tri_reg    <= tri_next;
            part_reg   <= part_next;
            pad_reg    <= pad_next;
        end
    end

endmodule

`default_nettype wire

/* src/bsp_out_queue.sv */
`default_nettype none

module bsp_out_queue import bsp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  push_count,
    input  wire bsp_result_t push0,
    input  wire bsp_result_t push1,
    output logic             room,
    output logic             out_valid,
    input  wire logic        out_ready,
    output bsp_result_t      out_item
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    bsp_result_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign room      = cnt_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_item  = entry_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = wr_reg + PTR_W'(push_count);
        rd_next  = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_reg + PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* src/bmp_24bit_stream_parser_unit.sv */
// BMP 24-bit stream parser.
// Input channel s_*: one file byte per transaction, s_tlast on the last byte
// of each file; the byte after it opens a new file.
// Output channel m_*: one transaction per pixel (colour, column, row from
// the top) or one status transaction for a bad header, bad pixel offset or
// a file that ends early. m_tlast marks the final pixel of an image;
// m_tuser[3] marks the last transaction caused by one input byte.
// Each result enters the output queue as its byte is taken and reaches m_*
// once the entries ahead of it have gone. One byte per cycle while s_tready
// is high. The header and pixel state machine updates on every accepted
// byte and writes its results into a four-entry output queue; s_tready is
// high while at least two entries are free. A stalled receiver fills the
// queue and then holds s_tready low; nothing is dropped. A byte that ends a
// file mid-image may cause two results. Reset (aresetn low, synchronous)
// clears the parser to the start of a file and empties the queue.
`default_nettype none

module bmp_24bit_stream_parser_unit import bsp_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // blue[7:0], green[15:8], red[23:16],
                                        // column[35:24], row[47:36]
    output logic             m_tlast,
    output logic [3:0]       m_tuser    // status[2:0], run_end[3]
);

    bsp_result_t res0;
    bsp_result_t res1;
    bsp_result_t head;
    logic [1:0]  res_count;
    logic [1:0]  push_count;
    logic        room;
    logic        accept;

    assign s_tready   = room;
    assign accept     = s_tvalid && room;
    assign push_count = accept ? res_count : 2'd0;

    bsp_parser #(
        .MAX_DIM(MAX_DIM)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .data_byte (s_tdata),
        .file_end  (s_tlast),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    bsp_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (head)
    );

    assign m_tdata = {head.row, head.column, head.red, head.green, head.blue};
    assign m_tlast = head.last_pixel;
    assign m_tuser = {head.run_end, head.status};

endmodule

`default_nettype wire

/* src/bsp_checker.sv */
`default_nettype none

module bsp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [3:0]  m_tuser
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid directly after reset");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] != 3'd0) |-> (m_tdata == 48'd0 && !m_tlast))
        else $error("status transaction carries pixel fields");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2:0] != 3'd6 && m_tuser[2:0] != 3'd7))
        else $error("status code out of range");

    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] == 3'd5) |-> m_tuser[3])
        else $error("truncation not last transaction of its byte");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output transaction changed");

endmodule

bind bmp_24bit_stream_parser_unit bsp_checker u_bsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/bsp_stream_checker.sv */
`timescale 1ns / 100ps

module bsp_stream_checker import bsp_pkg::*; #(
    parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // blue[7:0], green[15:8], red[23:16],
                                        // column[35:24], row[47:36]
    input  wire logic        m_tlast,
    input  wire logic [3:0]  m_tuser,   // status[2:0], run_end[3]
    output int               mismatch_count,
    output int               results_waiting
);

    logic [2:0]  phase;
    logic [31:0] byte_pos;
    logic [31:0] pix_ofs;
    logic [31:0] info_len;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [31:0] compr;
    logic [31:0] col;
    logic [31:0] frow;
    logic [15:0] sig;
    logic [15:0] planes;
    logic [15:0] depth;
    logic [15:0] partial;
    int          tri_idx;
    int          pad_left;
    bsp_result_t results_due[$];

    task automatic start_new_file();
        phase    = PH_HEADER;
        byte_pos = '0;
        pix_ofs  = '0;
        info_len = '0;
        img_w    = '0;
        img_h    = '0;
        compr    = '0;
        col      = '0;
        frow     = '0;
        sig      = '0;
        planes   = '0;
        depth    = '0;
        partial  = '0;
        tri_idx  = 0;
        pad_left = 0;
    endtask

    function automatic bsp_result_t status_only(input logic [2:0] st);
        bsp_result_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    task automatic advance_parser(input logic [7:0] v, input logic fin);
        bsp_result_t made[2];
        int          n;
        logic [2:0]  verdict;
        n = 0;
        case (phase)
            PH_HEADER: begin
                if (byte_pos < 2)
                    sig = sig | (16'(v) << (8 * byte_pos));
                else if (byte_pos >= 10 && byte_pos < 14)
                    pix_ofs = pix_ofs | (32'(v) << (8 * (byte_pos - 10)));
                else if (byte_pos >= 14 && byte_pos < 18)
                    info_len = info_len | (32'(v) << (8 * (byte_pos - 14)));
                else if (byte_pos >= 18 && byte_pos < 22)
                    img_w = img_w | (32'(v) << (8 * (byte_pos - 18)));
                else if (byte_pos >= 22 && byte_pos < 26)
                    img_h = img_h | (32'(v) << (8 * (byte_pos - 22)));
                else if (byte_pos >= 26 && byte_pos < 28)
                    planes = planes | (16'(v) << (8 * (byte_pos - 26)));
                else if (byte_pos >= 28 && byte_pos < 30)
                    depth = depth | (16'(v) << (8 * (byte_pos - 28)));
                else if (byte_pos >= 30 && byte_pos < 34)
                    compr = compr | (32'(v) << (8 * (byte_pos - 30)));
                byte_pos = byte_pos + 1;
                if (byte_pos == HEADER_BYTES) begin
                    if (sig != BMP_SIGNATURE)
                        verdict = ST_BAD_SIG;
                    else if (info_len != INFO_BYTES || planes != PLANES_ONE ||
                             depth != DEPTH_24 || compr != 0)
                        verdict = ST_BAD_FMT;
                    else if (img_w == 0 || img_w > MAX_DIM || img_h == 0 || img_h > MAX_DIM)
                        verdict = ST_BAD_SIZE;
                    else if (pix_ofs < HEADER_BYTES)
                        verdict = ST_BAD_OFS;
                    else
                        verdict = ST_PIXEL;
                    if (verdict != ST_PIXEL) begin
                        made[n] = status_only(verdict);
                        n++;
                        phase = PH_ERROR;
                    end else begin
                        phase = (pix_ofs == HEADER_BYTES) ? PH_PIXELS : PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                byte_pos = byte_pos + 1;
                if (byte_pos == pix_ofs)
                    phase = PH_PIXELS;
            end
            PH_PIXELS: begin
                if (pad_left > 0) begin
                    pad_left--;
                    if (pad_left == 0 && frow >= img_h)
                        phase = PH_DONE;
                end else if (tri_idx < 2) begin
                    partial = partial | (16'(v) << (8 * tri_idx));
                    tri_idx++;
                end else begin
                    made[n]            = '0;
                    made[n].blue       = partial[7:0];
                    made[n].green      = partial[15:8];
                    made[n].red        = v;
                    made[n].column     = col[11:0];
                    made[n].row        = 12'(img_h - 32'd1 - frow);
                    made[n].last_pixel = (frow == img_h - 32'd1) && (col == img_w - 32'd1);
                    made[n].status     = ST_PIXEL;
                    n++;
                    tri_idx = 0;
                    partial = '0;
                    col = col + 1;
                    if (col >= img_w) begin
                        col      = '0;
                        frow     = frow + 1;
                        pad_left = (4 - ((img_w * 3) % 4)) % 4;
                        if (pad_left == 0 && frow >= img_h)
                            phase = PH_DONE;
                    end
                end
            end
            default: ;
        endcase

        if (fin) begin
            if (phase == PH_HEADER || phase == PH_SKIP || phase == PH_PIXELS) begin
                made[n] = status_only(ST_TRUNCATED);
                n++;
            end
            start_new_file();
        end

        if (n > 0)
            made[n - 1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            results_due.push_back(made[i]);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [11:0] got,
                                 input logic [11:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    task automatic check_result();
        bsp_result_t want;
        if (results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction tdata=%h tlast=%b tuser=%h",
                                      m_tdata, m_tlast, m_tuser));
        end else begin
            want = results_due.pop_front();
            compare_field("blue", 12'(m_tdata[7:0]), 12'(want.blue));
            compare_field("green", 12'(m_tdata[15:8]), 12'(want.green));
            compare_field("red", 12'(m_tdata[23:16]), 12'(want.red));
            compare_field("column", m_tdata[35:24], want.column);
            compare_field("row", m_tdata[47:36], want.row);
            compare_field("last_pixel", 12'(m_tlast), 12'(want.last_pixel));
            compare_field("status", 12'(m_tuser[2:0]), 12'(want.status));
            compare_field("run_end", 12'(m_tuser[3]), 12'(want.run_end));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_new_file();
            results_due.delete();
            mismatch_count = 0;
        end else begin
            if (s_tvalid && s_tready)
                advance_parser(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
        results_waiting <= results_due.size();
    end

endmodule

/* tb/tb_bmp_24bit_stream_parser_unit.sv */
`timescale 1ns / 100ps

module tb_bmp_24bit_stream_parser_unit import bsp_pkg::*; ();

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    int          mismatch_count;
    int          results_waiting;
    logic        quiet      = 1'b0;
    int          stall_left = 0;
    int          bytes_sent = 0;
    logic [7:0]  file_q[$];

    always #5 aclk = ~aclk;

    bmp_24bit_stream_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    bsp_stream_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_waiting (results_waiting)
    );

    // hold off the result channel in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                stall_left <= $urandom_range(1, 16);
        end
    end

    task automatic send_byte(input logic [7:0] v, input logic fin);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic push_le(input logic [31:0] val, input int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(val[8 * i +: 8]);
    endtask

    task automatic build_file(input logic [15:0] sig, input logic [31:0] info,
                              input logic [15:0] planes, input logic [15:0] depth,
                              input logic [31:0] compr, input logic [31:0] wd,
                              input logic [31:0] ht, input logic [31:0] ofs,
                              input bit body, input int trail);
        int pad;
        file_q.delete();
        push_le(32'(sig), 2);
        push_le($urandom, 4);
        push_le($urandom, 4);
        push_le(ofs, 4);
        push_le(info, 4);
        push_le(wd, 4);
        push_le(ht, 4);
        push_le(32'(planes), 2);
        push_le(32'(depth), 2);
        push_le(compr, 4);
        repeat (20) file_q.push_back(8'($urandom));
        if (body) begin
            repeat (ofs - HEADER_BYTES) file_q.push_back(8'($urandom));
            pad = (4 - ((wd * 3) % 4)) % 4;
            repeat (ht) begin
                repeat (wd * 3) file_q.push_back(8'($urandom));
                repeat (pad) file_q.push_back(8'($urandom));
            end
        end
        repeat (trail) file_q.push_back(8'($urandom));
    endtask

    task automatic good_file(input logic [31:0] wd, input logic [31:0] ht,
                             input logic [31:0] ofs, input int trail);
        build_file(BMP_SIGNATURE, INFO_BYTES, PLANES_ONE, DEPTH_24, '0, wd, ht, ofs,
                   1'b1, trail);
    endtask

    task automatic send_file(input int keep);
        int n;
        n = (keep > 0 && keep < file_q.size()) ? keep : file_q.size();
        for (int i = 0; i < n; i++)
            send_byte(file_q[i], i == n - 1);
    endtask

    initial begin
        int          start;
        int          keep;
        int          trail;
        bit          body;
        logic [15:0] sig;
        logic [15:0] planes;
        logic [15:0] depth;
        logic [31:0] info;
        logic [31:0] compr;
        logic [31:0] wd;
        logic [31:0] ht;
        logic [31:0] ofs;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        good_file(2, 2, HEADER_BYTES, 3);
        send_file(0);

        build_file(BMP_SIGNATURE ^ 16'h0100, INFO_BYTES, PLANES_ONE, DEPTH_24, '0, 2, 2,
                   HEADER_BYTES, 1'b0, 2);
        send_file(0);
        build_file(BMP_SIGNATURE, INFO_BYTES, PLANES_ONE, DEPTH_24, '0, 32'h8000_0000, 2,
                   HEADER_BYTES, 1'b0, 0);
        send_file(0);
        build_file(BMP_SIGNATURE, INFO_BYTES, PLANES_ONE, DEPTH_24, '0, 2, 2,
                   HEADER_BYTES - 1, 1'b0, 3);
        send_file(0);

        // early file ends: on a pixel, on the final pixel before its padding, in a header
        good_file(2, 2, HEADER_BYTES, 0);
        send_file(HEADER_BYTES + 6);
        good_file(1, 1, HEADER_BYTES, 0);
        send_file(HEADER_BYTES + 3);
        send_byte(8'hFF, 1'b1);

        start = bytes_sent;
        while (bytes_sent - start < 100) begin
            quiet  = (bytes_sent - start >= 40) || ($urandom_range(0, 4) == 0);
            sig    = BMP_SIGNATURE;
            info   = INFO_BYTES;
            planes = PLANES_ONE;
            depth  = DEPTH_24;
            compr  = '0;
            wd     = $urandom_range(1, 9);
            ht     = $urandom_range(1, 4);
            ofs    = HEADER_BYTES + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0);
            body   = 1'b1;
            keep   = 0;
            trail  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
            case ($urandom_range(0, 9))
                0, 1: begin
                    body  = 1'b0;
                    trail = $urandom_range(0, 6);
                    case ($urandom_range(0, 7))
                        0: sig    = sig ^ 16'($urandom_range(1, 16'hFFFF));
                        1: info   = info ^ ($urandom | 32'h1);
                        2: planes = planes ^ 16'($urandom_range(1, 16'hFFFF));
                        3: depth  = depth ^ 16'($urandom_range(1, 16'hFFFF));
                        4: compr  = $urandom | 32'h1;
                        5: wd     = ($urandom_range(0, 2) == 0) ? '0 : ($urandom | 32'h2000);
                        6: ht     = ($urandom_range(0, 2) == 0) ? '0 : ($urandom | 32'h2000);
                        default: ofs = $urandom_range(0, HEADER_BYTES - 1);
                    endcase
                    build_file(sig, info, planes, depth, compr, wd, ht, ofs, body, trail);
                end
                2: begin
                    good_file(wd, ht, ofs, 0);
                    keep = $urandom_range(1, file_q.size());
                end
                3: begin
                    file_q.delete();
                    repeat ($urandom_range(1, 70)) file_q.push_back(8'($urandom));
                end
                default: good_file(wd, ht, ofs, trail);
            endcase
            send_file(keep);
        end

        quiet = 1'b1;
        s_tvalid <= 1'b0;
        while (results_waiting != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
